// ===== rtl/fpsq_pkg.sv =====
package fpsq_pkg;

    localparam int FRAC_BITS = 28;

    // mantissa magnitude register holds a positive 31-bit value
    localparam int XX_W = 31;
    // adjusted exponent: 16-bit input moved by at most about thirty shifts
    localparam int NN_W = 18;

    localparam logic [XX_W-1:0] ONE_Q = XX_W'(1) << FRAC_BITS;

    localparam logic signed [31:0] ROOT2_Q     = 32'sd379625056;
    localparam logic signed [31:0] ROOT_HALF_Q = 32'sd189812528;

    localparam logic signed [NN_W-1:0] SHIFT_MAX  = NN_W'(32767);
    localparam logic signed [NN_W-1:0] SHIFT_MIN  = -NN_W'(32768);
    localparam logic signed [NN_W-1:0] SHIFT_BIAS = NN_W'(FRAC_BITS + 1);

    localparam int UCODE_LEN = 27;
    localparam int PC_W      = $clog2(UCODE_LEN);
    localparam int CIDX_W    = 4;

    typedef struct packed {
        logic signed [31:0] mantissa;
        logic signed [15:0] exponent;
    } t_in;

    typedef struct packed {
        logic signed [31:0] root;
        logic signed [15:0] shift_amount;
    } t_out;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_HALVE,
        OP_NORMUP,
        OP_LDC0,
        OP_MULX,
        OP_ADDC,
        OP_MULK,
        OP_FIXK,
        OP_DONE
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NONPOS,
        C_LT_ONE,
        C_LE_ONE,
        C_NORM_MORE,
        C_EVEN
    } t_cond;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        t_op               op;
        t_cond             cond;
        logic [PC_W-1:0]   target;
        logic [CIDX_W-1:0] cidx;
    } t_ucw;

    typedef struct packed {
        logic load;
        logic emit;
        t_op  op;
        logic [CIDX_W-1:0] cidx;
    } t_ctrl;

    typedef struct packed {
        logic nonpos;
        logic lt_one;
        logic le_one;
        logic norm_more;
        logic nn_even;
    } t_flags;

    function automatic logic signed [31:0] coef(input logic [CIDX_W-1:0] k);
        logic signed [31:0] c;
        unique case (k)
            4'd0:    c = -32'sd37123928;
            4'd1:    c = 32'sd256042864;
            4'd2:    c = -32'sd785937664;
            4'd3:    c = 32'sd1415806976;
            4'd4:    c = -32'sd1665031168;
            4'd5:    c = 32'sd1354840576;
            4'd6:    c = -32'sd814333312;
            4'd7:    c = 32'sd499769952;
            4'd8:    c = 32'sd44401260;
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic t_ucw uw(input t_op op, input t_cond cond, input int target,
                                input int cidx);
        t_ucw w;
        w.op     = op;
        w.cond   = cond;
        w.target = PC_W'(target);
        w.cidx   = CIDX_W'(cidx);
        return w;
    endfunction

    // control store: range reduction, horner loop, odd-exponent correction
    function automatic t_ucw ucode(input logic [PC_W-1:0] pc);
        t_ucw w;
        unique case (pc)
            5'd0:    w = uw(OP_NOP,    C_NONPOS,    26, 0);
            5'd1:    w = uw(OP_NOP,    C_LT_ONE,    5,  0);
            5'd2:    w = uw(OP_HALVE,  C_NEVER,     0,  0);
            5'd3:    w = uw(OP_NOP,    C_LE_ONE,    6,  0);
            5'd4:    w = uw(OP_HALVE,  C_ALWAYS,    3,  0);
            5'd5:    w = uw(OP_NORMUP, C_NORM_MORE, 5,  0);
            5'd6:    w = uw(OP_LDC0,   C_NEVER,     0,  0);
            5'd7:    w = uw(OP_MULX,   C_NEVER,     0,  0);
            5'd8:    w = uw(OP_ADDC,   C_NEVER,     0,  1);
            5'd9:    w = uw(OP_MULX,   C_NEVER,     0,  0);
            5'd10:   w = uw(OP_ADDC,   C_NEVER,     0,  2);
            5'd11:   w = uw(OP_MULX,   C_NEVER,     0,  0);
            5'd12:   w = uw(OP_ADDC,   C_NEVER,     0,  3);
            5'd13:   w = uw(OP_MULX,   C_NEVER,     0,  0);
            5'd14:   w = uw(OP_ADDC,   C_NEVER,     0,  4);
            5'd15:   w = uw(OP_MULX,   C_NEVER,     0,  0);
            5'd16:   w = uw(OP_ADDC,   C_NEVER,     0,  5);
            5'd17:   w = uw(OP_MULX,   C_NEVER,     0,  0);
            5'd18:   w = uw(OP_ADDC,   C_NEVER,     0,  6);
            5'd19:   w = uw(OP_MULX,   C_NEVER,     0,  0);
            5'd20:   w = uw(OP_ADDC,   C_NEVER,     0,  7);
            5'd21:   w = uw(OP_MULX,   C_NEVER,     0,  0);
            5'd22:   w = uw(OP_ADDC,   C_NEVER,     0,  8);
            5'd23:   w = uw(OP_NOP,    C_EVEN,      26, 0);
            5'd24:   w = uw(OP_MULK,   C_NEVER,     0,  0);
            5'd25:   w = uw(OP_FIXK,   C_NEVER,     0,  0);
            default: w = uw(OP_DONE,   C_NEVER,     0,  0);
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/fpsq_if.sv =====
interface fpsq_in_if;
    import fpsq_pkg::*;

    logic valid;
    logic ready;
    t_in  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface fpsq_out_if;
    import fpsq_pkg::*;

    logic valid;
    logic ready;
    t_out data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/fpsq_seq.sv =====
module fpsq_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic              i_out_block,
    input  fpsq_pkg::t_flags  i_flags,
    output logic              o_req_ready,
    output fpsq_pkg::t_ctrl   o_ctrl
);
    import fpsq_pkg::*;

    t_state          r_state, n_state;
    logic [PC_W-1:0] r_pc, n_pc;
    t_ucw            cw;
    logic            cond_hit;

    // control word fetch and branch condition
    always_comb begin
        cw = ucode(r_pc);
        unique case (cw.cond)
            C_NEVER:     cond_hit = 1'b0;
            C_ALWAYS:    cond_hit = 1'b1;
            C_NONPOS:    cond_hit = i_flags.nonpos;
            C_LT_ONE:    cond_hit = i_flags.lt_one;
            C_LE_ONE:    cond_hit = i_flags.le_one;
            C_NORM_MORE: cond_hit = i_flags.norm_more;
            C_EVEN:      cond_hit = i_flags.nn_even;
            default:     cond_hit = 1'b0;
        endcase
    end

    // outputs
    always_comb begin
        o_req_ready  = (r_state == ST_IDLE);
        o_ctrl.load  = i_req_valid && (r_state == ST_IDLE);
        o_ctrl.emit  = 1'b0;
        o_ctrl.op    = OP_NOP;
        o_ctrl.cidx  = cw.cidx;
        unique case (r_state)
            ST_IDLE: begin
                o_ctrl.op = OP_NOP;
            end
            ST_RUN: begin
                if (cw.op == OP_DONE) begin
                    o_ctrl.emit = !i_out_block;
                    o_ctrl.op   = i_out_block ? OP_NOP : OP_DONE;
                end else begin
                    o_ctrl.op = cw.op;
                end
            end
            default: o_ctrl.op = OP_NOP;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_state = ST_RUN;
                    n_pc    = '0;
                end
            end
            ST_RUN: begin
                if (cw.op == OP_DONE) begin
                    if (!i_out_block) begin
                        n_state = ST_IDLE;
                    end
                end else if (cond_hit) begin
                    n_pc = cw.target;
                end else begin
                    n_pc = r_pc + PC_W'(1);
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

    a_load_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.load |=> (r_state == ST_RUN) && (r_pc == '0))
        else $error("request accepted but program did not start at step zero");

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_pc < PC_W'(UCODE_LEN)))
        else $error("step counter left the control store");

    a_emit_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.emit |=> (r_state == ST_IDLE))
        else $error("sequencer still running after result emitted");

endmodule

// ===== rtl/fpsq_dp.sv =====
module fpsq_dp (
    input  logic             i_clk,
    input  fpsq_pkg::t_ctrl  i_ctrl,
    input  fpsq_pkg::t_in    i_data,
    output fpsq_pkg::t_flags o_flags,
    output fpsq_pkg::t_out   o_result
);
    import fpsq_pkg::*;

    logic [XX_W-1:0]        r_xx, n_xx;
    logic signed [NN_W-1:0] r_nn, n_nn;
    logic                   r_nonpos, n_nonpos;
    logic signed [31:0]     r_acc, n_acc;
    logic signed [63:0]     r_prod, n_prod;

    logic [2:0]             up_sh;
    logic signed [31:0]     mul_b;
    logic signed [31:0]     prod_q28;
    logic signed [31:0]     prod_q29;
    logic signed [NN_W-1:0] sf;

    // left shift toward bit FRAC_BITS-1, at most four places a step
    always_comb begin
        if (r_xx[FRAC_BITS-1 -: 4] == 4'd0) begin
            up_sh = 3'd4;
        end else if (r_xx[FRAC_BITS-1]) begin
            up_sh = 3'd0;
        end else if (r_xx[FRAC_BITS-2]) begin
            up_sh = 3'd1;
        end else if (r_xx[FRAC_BITS-3]) begin
            up_sh = 3'd2;
        end else begin
            up_sh = 3'd3;
        end
    end

    assign prod_q28 = $signed(r_prod[FRAC_BITS+31:FRAC_BITS]);
    assign prod_q29 = $signed(r_prod[FRAC_BITS+32:FRAC_BITS+1]);

    always_comb begin
        if (i_ctrl.op == OP_MULK) begin
            mul_b = r_nn[NN_W-1] ? ROOT_HALF_Q : ROOT2_Q;
        end else begin
            mul_b = $signed({1'b0, r_xx});
        end
    end

    always_comb begin
        n_xx     = r_xx;
        n_nn     = r_nn;
        n_nonpos = r_nonpos;
        n_acc    = r_acc;
        n_prod   = r_prod;
        if (i_ctrl.load) begin
            n_xx     = i_data.mantissa[XX_W-1:0];
            n_nn     = {{(NN_W-16){i_data.exponent[15]}}, i_data.exponent};
            n_nonpos = (i_data.mantissa <= 32'sd0);
        end else begin
            case (i_ctrl.op)
                OP_HALVE: begin
                    n_xx = r_xx >> 1;
                    n_nn = r_nn + NN_W'(1);
                end
                OP_NORMUP: begin
                    n_xx = r_xx << up_sh;
                    n_nn = r_nn - $signed({{(NN_W-3){1'b0}}, up_sh});
                end
                OP_LDC0:          n_acc  = coef(i_ctrl.cidx);
                OP_MULX, OP_MULK: n_prod = r_acc * mul_b;
                OP_ADDC:          n_acc  = prod_q28 + coef(i_ctrl.cidx);
                OP_FIXK:          n_acc  = r_nn[NN_W-1] ? prod_q28 : prod_q29;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_xx     <= n_xx;
        r_nn     <= n_nn;
        r_nonpos <= n_nonpos;
        r_acc    <= n_acc;
        r_prod   <= n_prod;
    end

    assign o_flags.nonpos    = r_nonpos;
    assign o_flags.lt_one    = (r_xx < ONE_Q);
    assign o_flags.le_one    = (r_xx <= ONE_Q);
    assign o_flags.norm_more = (r_xx[FRAC_BITS-1 -: 5] == 5'd0);
    assign o_flags.nn_even   = !r_nn[0];

    // half the exponent, one more when odd, less the fraction bias
    assign sf = (r_nn >>> 1) + $signed({{(NN_W-1){1'b0}}, r_nn[0]}) - SHIFT_BIAS;

    always_comb begin
        if (r_nonpos) begin
            o_result.root         = '0;
            o_result.shift_amount = '0;
        end else begin
            o_result.root = r_acc;
            if (sf > SHIFT_MAX) begin
                o_result.shift_amount = SHIFT_MAX[15:0];
            end else if (sf < SHIFT_MIN) begin
                o_result.shift_amount = SHIFT_MIN[15:0];
            end else begin
                o_result.shift_amount = sf[15:0];
            end
        end
    end

endmodule

// ===== rtl/fixed_point_square_root_unit.sv =====
// square root of a value given as a q28 mantissa and a binary exponent; each
// request returns the root mantissa and the binary shift to apply to it. a
// non-positive mantissa gives root 0 and shift 0. the mantissa is brought into
// [0.5, 1.0] (halving one bit at a time from above, each halving followed by a
// test, doubling up to four bits a cycle from below), a degree-8 horner
// polynomial runs on one shared 32x32 signed multiplier, and an odd exponent
// takes a sqrt(2) or sqrt(1/2) step. everything is driven by a 27-step
// microprogram in a constant control store with a step counter and conditional
// jumps. a non-positive mantissa goes straight from the sign test to the hand-over;
// otherwise the steps are the sign test and range reduction, the leading
// coefficient load and the eight multiply/add pairs of the horner loop (every
// product is registered before its add), the parity test, the correction for
// an odd exponent and the hand-over. a new request is accepted only while the
// sequencer is idle, but a finished result sits in an output register so the
// next request can start while it waits to be taken
module fixed_point_square_root_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fpsq_in_if.sink     i_req,
    fpsq_out_if.source  o_rsp
);
    import fpsq_pkg::*;

    t_ctrl  ctrl;
    t_flags flags;
    t_out   result;
    logic   out_block;

    logic   r_out_valid, n_out_valid;
    t_out   r_out_data, n_out_data;

    // the output register is full and not being drained this cycle
    assign out_block = r_out_valid && !o_rsp.ready;

    fpsq_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_out_block (out_block),
        .i_flags     (flags),
        .o_req_ready (i_req.ready),
        .o_ctrl      (ctrl)
    );

    fpsq_dp u_dp (
        .i_clk    (i_clk),
        .i_ctrl   (ctrl),
        .i_data   (i_req.data),
        .o_flags  (flags),
        .o_result (result)
    );

    // output register: loaded on emit, cleared once the result is taken
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (ctrl.emit) begin
            n_out_valid = 1'b1;
            n_out_data  = result;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        r_out_data <= n_out_data;
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out_data;

    // a result is never written over one that has not been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.emit |-> !out_block)
        else $error("result emitted into a full output register");

    // no request is accepted while the previous one is still in the datapath
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.load |=> !i_req.ready)
        else $error("request port open while a request is in flight");

    // a zero or negative mantissa always yields an all-zero result
    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.emit && flags.nonpos) |=> (o_rsp.data.root == '0)
            && (o_rsp.data.shift_amount == '0))
        else $error("non-positive mantissa gave a non-zero result");

endmodule
